FILE: sv/prd_pkg.sv
// Package for the PCX run-length pixel decoder: register indexes, byte codes,
// controller/datapath command and status types and the lane packing function.
// Depends on nothing; every module of the decoder imports it.
package prd_pkg;

	localparam int CfgIdxW = 4;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_BITS_PER_PIXEL = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_PLANE_COUNT = 4'd3;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [7:0] RUN_LEN_MASK = 8'h3F;
	localparam logic [7:0] LANE_MASK = 8'hFF;

	typedef struct packed {
		logic take;
		logic emit;
		logic from_input;
	} prd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic header;
		logic pending;
		logic zero_run;
		logic emit_last;
	} prd_stat_t;

	// Splits one byte into pixels of 2**lg bits, most significant first, and
	// shifts each by the plane offset. Lanes at or beyond valid stay zero.
	function automatic logic [63:0] pack_lanes(logic [7:0] b, logic [1:0] lg,
		logic [2:0] plane, logic [3:0] valid);
		logic [63:0] r;
		logic [15:0] v;
		logic [5:0] sh;
		logic [3:0] ppb;
		logic [3:0] bpp;
		logic [7:0] mask;
		logic [3:0] pos;
		bpp = 4'd1 << lg;
		ppb = 4'd8 >> lg;
		mask = 8'((16'd1 << bpp) - 16'd1);
		sh = 6'({3'b000, plane} << lg);
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < valid) begin
				pos = 4'((ppb - 4'd1 - 4'(i)) << lg);
				v = {8'h00, (b >> pos) & mask};
				if (sh < 6'd8) begin
					r[8*i +: 8] = 8'(v << sh[2:0]) & LANE_MASK;
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/pcx_rle_pixel_decoder_core.sv
// PCX run-length pixel decoder, top level. Depends on prd_pkg, prd_ctrl, prd_datapath.
// A literal byte's result appears in the cycle after it is taken. A run header gives no
// result; the data byte then gives up to n results, fewer where the plane line ends, one
// per cycle from the output register while out_stall is low, and input stalls meanwhile.
// Reset clears all counters and run state and loads the register defaults at once.
module pcx_rle_pixel_decoder_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [prd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [prd_pkg::CfgDataW-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                stream_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               pixel_row,
	output logic [15:0]               first_x,
	output logic [3:0]                pixel_count,
	output logic [63:0]               pixel_lanes,
	output logic [2:0]                plane_index,
	output logic                      run_last,
	output logic                      frame_last
);
	import prd_pkg::*;

	prd_cmd_t  cmd;
	prd_stat_t stat;

	assign cfg_ready = 1'b1;

	prd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	prd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stream_byte (stream_byte),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_row   (pixel_row),
		.first_x     (first_x),
		.pixel_count (pixel_count),
		.pixel_lanes (pixel_lanes),
		.plane_index (plane_index),
		.run_last    (run_last),
		.frame_last  (frame_last),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

FILE: sv/prd_ctrl.sv
// Controller of the PCX run-length pixel decoder: a two-state machine that
// takes bytes and paces the results of a run. Depends on prd_pkg.
module prd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  prd_pkg::prd_stat_t stat,
	output prd_pkg::prd_cmd_t  cmd
);
	import prd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} prd_state_t;

	prd_state_t state_q;
	prd_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = !stat.out_free;
				cmd.from_input = 1'b1;
				cmd.take = in_valid && stat.out_free;
				cmd.emit = cmd.take && !(stat.header && !stat.pending) && !stat.zero_run;
				if (cmd.emit && !stat.emit_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.emit = stat.out_free;
				if (cmd.emit && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/prd_datapath.sv
// Datapath of the PCX run-length pixel decoder: configuration registers,
// position counters, run state and the registered result. Depends on prd_pkg.
module prd_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [prd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [prd_pkg::CfgDataW-1:0] cfg_data,
	input  logic [7:0]                stream_byte,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [15:0]               pixel_row,
	output logic [15:0]               first_x,
	output logic [3:0]                pixel_count,
	output logic [63:0]               pixel_lanes,
	output logic [2:0]                plane_index,
	output logic                      run_last,
	output logic                      frame_last,
	input  prd_pkg::prd_cmd_t          cmd,
	output prd_pkg::prd_stat_t         stat
);
	import prd_pkg::*;

	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [3:0]  bpp_q;
	logic [3:0]  planes_q;

	logic [15:0] row_q;
	logic [2:0]  plane_q;
	logic [15:0] col_q;
	logic        pending_q;
	logic [5:0]  run_len_q;
	logic [5:0]  remain_q;
	logic [7:0]  byte_q;
	logic        out_valid_q;

	logic [16:0] w;
	logic [16:0] h;
	logic [3:0]  planes;
	logic [1:0]  lg;
	logic [3:0]  ppb;
	logic [16:0] line_len;
	logic [15:0] row_n;
	logic [2:0]  plane_n;
	logic [15:0] col_n;
	logic [18:0] x0;
	logic [16:0] avail;
	logic [3:0]  valid_n;
	logic [7:0]  byte_cur;
	logic [5:0]  count_cur;
	logic        line_end;
	logic        plane_wrap;
	logic        row_wrap;

	always_comb begin
		w = (width_q == 16'd0) ? 17'd1 : {1'b0, width_q};
		h = (height_q == 16'd0) ? 17'd1 : {1'b0, height_q};
		if (planes_q == 4'd0) begin
			planes = 4'd1;
		end else if (planes_q > 4'd8) begin
			planes = 4'd8;
		end else begin
			planes = planes_q;
		end
		case (bpp_q)
			4'd1: lg = 2'd0;
			4'd2: lg = 2'd1;
			4'd8: lg = 2'd3;
			default: lg = 2'd2;
		endcase
		ppb = 4'd8 >> lg;
		line_len = (w + 17'(ppb) - 17'd1) >> (2'd3 - lg);

		row_n = ({1'b0, row_q} >= h) ? 16'd0 : row_q;
		plane_n = ({1'b0, plane_q} >= planes) ? 3'd0 : plane_q;
		col_n = ({1'b0, col_q} >= line_len) ? 16'd0 : col_q;

		x0 = {3'b000, col_n} << (2'd3 - lg);
		avail = w - x0[16:0];
		valid_n = (avail > 17'(ppb)) ? ppb : avail[3:0];

		byte_cur = cmd.from_input ? stream_byte : byte_q;
		if (cmd.from_input) begin
			count_cur = pending_q ? run_len_q : 6'd1;
		end else begin
			count_cur = remain_q;
		end

		line_end = ({1'b0, col_n} + 17'd1) >= line_len;
		plane_wrap = ({1'b0, plane_n} + 4'd1) >= planes;
		row_wrap = ({1'b0, row_n} + 17'd1) >= h;

		stat.out_free = !out_valid_q || !out_stall;
		stat.header = (stream_byte & RUN_MARK) == RUN_MARK;
		stat.pending = pending_q;
		stat.zero_run = pending_q && (run_len_q == 6'd0);
		stat.emit_last = (count_cur == 6'd1) || line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd1;
			height_q <= 16'd1;
			bpp_q <= 4'd8;
			planes_q <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_BITS_PER_PIXEL: bpp_q <= cfg_data[3:0];
				REG_PLANE_COUNT: planes_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			run_len_q <= 6'd0;
			row_q <= 16'd0;
			plane_q <= 3'd0;
			col_q <= 16'd0;
			remain_q <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (!pending_q && stat.header) begin
					pending_q <= 1'b1;
					run_len_q <= stream_byte[5:0] & RUN_LEN_MASK[5:0];
				end else begin
					pending_q <= 1'b0;
					run_len_q <= 6'd0;
				end
			end
			if (cmd.emit) begin
				remain_q <= count_cur - 6'd1;
				out_valid_q <= 1'b1;
				if (line_end) begin
					col_q <= 16'd0;
					if (plane_wrap) begin
						plane_q <= 3'd0;
						row_q <= row_wrap ? 16'd0 : row_n + 16'd1;
					end else begin
						plane_q <= plane_n + 3'd1;
						row_q <= row_n;
					end
				end else begin
					col_q <= col_n + 16'd1;
					plane_q <= plane_n;
					row_q <= row_n;
				end
			end else begin
				if (cmd.take) begin
					col_q <= col_n;
					plane_q <= plane_n;
					row_q <= row_n;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= stream_byte;
		end
		if (cmd.emit) begin
			pixel_row <= row_n;
			first_x <= x0[15:0];
			pixel_count <= valid_n;
			pixel_lanes <= pack_lanes(byte_cur, lg, plane_n, valid_n);
			plane_index <= plane_n;
			run_last <= stat.emit_last;
			frame_last <= line_end && plane_wrap && row_wrap;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pcx_rle_pixel_decoder_core: feeds compressed bytes and
// register writes, predicts every pixel result and checks them in arrival order.
// Depends on prd_pkg and the decoder RTL.
module tb_top;
	import prd_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 25;
	localparam int RANDOM_PHASES = 8;
	localparam int MAX_REPORTS = 30;
	localparam int BUSY_PCT = 87;
	localparam int LIGHT_PCT = 13;
	localparam logic [CfgIdxW-1:0] REG_FIRST_SPARE = REG_PLANE_COUNT + 1'b1;
	localparam logic [CfgIdxW-1:0] REG_LAST_SPARE = '1;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] x;
		logic [3:0] count;
		logic [63:0] lanes;
		logic [2:0] plane;
		logic run_last;
		logic frame_last;
	} pixel_res_t;

	typedef struct packed {
		logic is_cfg;
		logic typed;
		logic [7:0] data;
		logic [15:0] width;
		logic [15:0] height;
		logic [3:0] bpp;
		logic [3:0] planes;
		pixel_res_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] stream_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] pixel_row;
	logic [15:0] first_x;
	logic [3:0] pixel_count;
	logic [63:0] pixel_lanes;
	logic [2:0] plane_index;
	logic run_last;
	logic frame_last;

	logic [15:0] img_w = 16'd1;
	logic [15:0] img_h = 16'd1;
	logic [3:0] img_bpp = 4'd8;
	logic [3:0] img_planes = 4'd1;
	logic [15:0] row_ctr = '0;
	logic [2:0] plane_ctr = '0;
	logic [15:0] col_ctr = '0;
	logic run_armed = 1'b0;
	logic [5:0] run_len = '0;

	pixel_res_t pending_pixels[$];
	stim_row_t directed[$];
	idle_mode_t idle_mode = IDLE_NONE;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int frames_seen = 0;
	int settings_used = 0;

	pcx_rle_pixel_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_row(pixel_row),
		.first_x(first_x),
		.pixel_count(pixel_count),
		.pixel_lanes(pixel_lanes),
		.plane_index(plane_index),
		.run_last(run_last),
		.frame_last(frame_last)
	);

	always #CLK_HALF clk = ~clk;

	// Decodes one accepted byte and queues the pixel results it gives.
	function automatic void decode_byte(input logic [7:0] b);
		int unsigned bpp, ppb, w, h, np, line_len, reps, valid, shift, v;
		pixel_res_t r;
		pixel_res_t batch[$];
		bit line_end;
		case (img_bpp)
			4'd1, 4'd2, 4'd8: bpp = img_bpp;
			default: bpp = 4;
		endcase
		ppb = 8 / bpp;
		w = (img_w == 0) ? 1 : img_w;
		h = (img_h == 0) ? 1 : img_h;
		np = (img_planes == 0) ? 1 : (img_planes > 8) ? 8 : img_planes;
		line_len = (w + ppb - 1) / ppb;
		if (row_ctr >= h) row_ctr = '0;
		if (plane_ctr >= np) plane_ctr = '0;
		if (col_ctr >= line_len) col_ctr = '0;
		if (!run_armed) begin
			if ((b & RUN_MARK) == RUN_MARK) begin
				run_armed = 1'b1;
				run_len = 6'(b & RUN_LEN_MASK);
				return;
			end
			reps = 1;
		end else begin
			reps = run_len;
			run_armed = 1'b0;
			run_len = '0;
		end
		for (int k = 0; k < reps; k++) begin
			r = '0;
			r.row = row_ctr;
			r.x = 16'(col_ctr * ppb);
			r.plane = plane_ctr;
			valid = w - col_ctr * ppb;
			if (valid > ppb) valid = ppb;
			r.count = 4'(valid);
			shift = bpp * plane_ctr;
			for (int i = 0; i < valid; i++) begin
				v = (b >> (bpp * (ppb - 1 - i))) & ((1 << bpp) - 1);
				if (shift < 8) r.lanes[8*i +: 8] = 8'(v << shift);
			end
			line_end = 1'b0;
			if (int'(col_ctr) + 1 >= line_len) begin
				line_end = 1'b1;
				col_ctr = '0;
				if (int'(plane_ctr) + 1 >= np) begin
					plane_ctr = '0;
					if (int'(row_ctr) + 1 >= h) begin
						row_ctr = '0;
						r.frame_last = 1'b1;
					end else row_ctr = row_ctr + 1'b1;
				end else plane_ctr = plane_ctr + 1'b1;
			end else col_ctr = col_ctr + 1'b1;
			batch.push_back(r);
			if (line_end) break;
		end
		if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[j]) pending_pixels.push_back(batch[j]);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		pixel_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (frame_last) frames_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected result at row", pixel_row, '0);
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_row !== want.row) report_mismatch("pixel_row", pixel_row, want.row);
				if (first_x !== want.x) report_mismatch("first_x", first_x, want.x);
				if (pixel_count !== want.count)
					report_mismatch("pixel_count", pixel_count, want.count);
				if (pixel_lanes !== want.lanes)
					report_mismatch("pixel_lanes", pixel_lanes, want.lanes);
				if (plane_index !== want.plane)
					report_mismatch("plane_index", plane_index, want.plane);
				if (run_last !== want.run_last)
					report_mismatch("run_last", run_last, want.run_last);
				if (frame_last !== want.frame_last)
					report_mismatch("frame_last", frame_last, want.frame_last);
			end
		end
	end

	// The long hold-off is counted here so the sender keeps offering items meanwhile.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				IDLE_RECEIVER: out_stall <= ($urandom_range(99) < BUSY_PCT);
				IDLE_BOTH: out_stall <= ($urandom_range(99) < LIGHT_PCT);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d idle cycles, %0d results outstanding.",
					quiet_cycles, pending_pixels.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic logic sender_rests();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < BUSY_PCT;
			IDLE_BOTH: return $urandom_range(99) < LIGHT_PCT;
			default: return 1'b0;
		endcase
	endfunction

	// A typed row replaces the predicted result of a literal with a fixed one.
	task automatic send_byte(input logic [7:0] b, input logic typed, input pixel_res_t fixed);
		stream_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
		if (typed) begin
			void'(pending_pixels.pop_back());
			pending_pixels.push_back(fixed);
		end
		bytes_sent++;
		if (sender_rests()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (sender_rests());
		end
	endtask

	task automatic send_random_items(input int n);
		int sent;
		int pick;
		logic [5:0] len;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_byte(8'($urandom), 1'b0, '0);
				sent++;
			end else if (pick < 45) begin
				case ($urandom_range(9))
					0: len = '0;
					1: len = '1;
					default: len = 6'($urandom_range(6, 1));
				endcase
				send_byte(RUN_MARK | 8'(len), 1'b0, '0);
				send_byte(8'($urandom), 1'b0, '0);
				sent += 2;
			end else begin
				send_byte(8'($urandom_range(8'hBF, 0)), 1'b0, '0);
				sent++;
			end
		end
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] w, input logic [15:0] h,
		input logic [3:0] bpp, input logic [3:0] planes);
		logic [CfgIdxW-1:0] idx [5];
		logic [CfgDataW-1:0] val [5];
		idx[0] = REG_IMAGE_WIDTH;
		idx[1] = REG_IMAGE_HEIGHT;
		idx[2] = REG_BITS_PER_PIXEL;
		idx[3] = REG_PLANE_COUNT;
		idx[4] = CfgIdxW'($urandom_range(REG_LAST_SPARE, REG_FIRST_SPARE));
		val[0] = w;
		val[1] = h;
		val[2] = {12'($urandom), bpp};
		val[3] = {12'($urandom), planes};
		val[4] = 16'($urandom);
		cfg_valid <= 1'b1;
		foreach (idx[i]) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_IMAGE_WIDTH: img_w = val[i];
				REG_IMAGE_HEIGHT: img_h = val[i];
				REG_BITS_PER_PIXEL: img_bpp = val[i][3:0];
				REG_PLANE_COUNT: img_planes = val[i][3:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic void tab_byte(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.data = b;
		directed.push_back(r);
	endfunction

	function automatic void tab_typed(input logic [7:0] b, input pixel_res_t res);
		stim_row_t r;
		r = '0;
		r.data = b;
		r.typed = 1'b1;
		r.result = res;
		directed.push_back(r);
	endfunction

	function automatic void tab_cfg(input logic [15:0] w, input logic [15:0] h,
		input logic [3:0] bpp, input logic [3:0] planes);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.width = w;
		r.height = h;
		r.bpp = bpp;
		r.planes = planes;
		directed.push_back(r);
	endfunction

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : stimulus
		logic [15:0] w_sel, h_sel;
		logic [3:0] bpp_sel, pl_sel;

		// With the reset registers every result fills the single pixel of a one-row frame.
		tab_typed(8'h00, pixel_res_t'{16'd0, 16'd0, 4'd1, 64'h00, 3'd0, 1'b1, 1'b1});
		tab_typed(8'hBF, pixel_res_t'{16'd0, 16'd0, 4'd1, 64'hBF, 3'd0, 1'b1, 1'b1});
		tab_byte(8'hC3);
		tab_typed(8'h55, pixel_res_t'{16'd0, 16'd0, 4'd1, 64'h55, 3'd0, 1'b1, 1'b1});
		tab_byte(8'hC0);
		tab_byte(8'h12);
		tab_byte(8'hFF);
		tab_typed(8'hAA, pixel_res_t'{16'd0, 16'd0, 4'd1, 64'hAA, 3'd0, 1'b1, 1'b1});
		tab_cfg(16'd0, 16'd0, 4'd1, 4'd8);
		tab_byte(8'h80);
		tab_byte(8'h01);
		tab_byte(8'hBF);
		tab_byte(8'h40);
		tab_byte(8'hC2);
		tab_byte(8'hFF);
		tab_byte(8'h2A);
		tab_byte(8'h15);
		tab_cfg(16'd13, 16'd2, 4'd2, 4'd4);
		tab_byte(8'hC5);
		tab_byte(8'hE4);
		tab_byte(8'h1B);
		tab_cfg(16'hFFFF, 16'hFFFF, 4'd0, 4'd0);
		tab_byte(8'hFF);
		tab_byte(8'h3C);
		tab_cfg(16'd9, 16'd1, 4'd4, 4'd3);
		tab_byte(8'hC5);
		tab_byte(8'h9E);
		tab_byte(8'hC9);
		tab_byte(8'h9E);
		tab_byte(8'h77);

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				settle_block();
				load_config(directed[i].width, directed[i].height, directed[i].bpp,
					directed[i].planes);
			end else begin
				send_byte(directed[i].data, directed[i].typed, directed[i].result);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_block();
			case (p)
				2: load_config('1, '1, 4'hF, 4'hF);
				5: load_config(16'd1, 16'd1, 4'd1, 4'd8);
				default: begin
					w_sel = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1));
					h_sel = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(5, 1));
					bpp_sel = ($urandom_range(9) < 7) ? (4'd1 << $urandom_range(3)) : 4'($urandom);
					if (bpp_sel == 4'd1) pl_sel = 4'($urandom_range(8, 1));
					else if ($urandom_range(4) == 0) pl_sel = 4'($urandom);
					else pl_sel = 4'd1;
					load_config(w_sel, h_sel, bpp_sel, pl_sel);
				end
			endcase
			idle_mode = idle_mode_t'(p % 4);
			// The output is held off for a long stretch so the decoder backs up into its input.
			if (p == 4) hold_request = 1'b1;
			send_random_items(PHASE_ITEMS / 2);
			if (p == 1) settle_block();
			send_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
		end
		settle_block();

		$display("Decoded %0d stream bytes into %0d pixel results under %0d register settings.",
			bytes_sent, results_seen, settings_used);
		$display("Frames completed: %0d; mismatches: %0d.", frames_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
